[rtl/core/dual_gamepad_serial_reader_defines.svh]
// Assertion helpers for the reader's top-level RTL.
`ifndef DUAL_GAMEPAD_SERIAL_READER_DEFINES_SVH
`define DUAL_GAMEPAD_SERIAL_READER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DGSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dgsr check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DGSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dgsr check failed");

`endif

[rtl/core/dgsr_pkg.sv]
package dgsr_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int MASK_COUNT = 8;

	// Button masks in code order: entry k decodes to code k+1.
	localparam logic [7:0] BUTTON_MASK [MASK_COUNT] = '{
		8'h08, 8'h04, 8'h02, 8'h01, 8'h20, 8'h10, 8'h40, 8'h80
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LATCH_HOLD = 2'd0,
		CFG_CLOCK_HIGH = 2'd1,
		CFG_CLOCK_LOW  = 2'd2,
		CFG_REPORT     = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_INIT  = 3'd1,
		PH_LATCH = 3'd2,
		PH_RISE  = 3'd3,
		PH_HIGH  = 3'd4,
		PH_LOWW  = 3'd5,
		PH_FINAL = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0] latch_hold_ticks;
		logic [7:0] clock_high_ticks;
		logic [7:0] clock_low_ticks;
		logic [7:0] report_period;
	} cfg_t;

	// Per-tick commands from the sequencer to both pad lanes.
	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
		logic done;
	} lane_ctrl_t;

	// Registered sequencer outputs seen by the merge stage.
	typedef struct packed {
		logic latch_out;
		logic clock_out;
		logic frame_done;
		logic report_strobe;
	} seq_status_t;

	typedef struct packed {
		logic pad_one_data;
		logic pad_two_data;
	} item_t;

	typedef struct packed {
		logic       latch_out;
		logic       clock_out;
		logic [3:0] pad_one_code;
		logic [4:0] pad_two_code;
		logic       frame_done;
		logic       report_strobe;
	} result_t;

endpackage

[rtl/core/dual_gamepad_serial_reader.sv]
// Channel   Direction  Handshake            Payload
// item      in         item_valid/stall     item_t: both pad data lines, one tick
// result    out        result_valid/stall   result_t: drives, codes, strobes
// cfg       in         cfg_valid/ready      cfg_index, cfg_data (8 bits)
//
// One item is accepted per cycle unless stalled; its result follows next cycle.
// The sequencer and lane registers hold the tick's state and serve as the
// result register, so an item is taken whenever the result slot is free or
// is being drained in the same cycle. A stalled result holds its payload.
// Reset clears all state; the registers return to their default values.
module dual_gamepad_serial_reader
	import dgsr_pkg::*;
#(
	parameter int BUTTON_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	`include "dual_gamepad_serial_reader_defines.svh"

	cfg_t        cfg_q;
	lane_ctrl_t  ctrl;
	seq_status_t status;
	logic        tick;
	logic        result_valid_q;
	logic [3:0]  code_one, code_two;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latch_hold_ticks <= 8'd2;
			cfg_q.clock_high_ticks <= 8'd2;
			cfg_q.clock_low_ticks  <= 8'd4;
			cfg_q.report_period    <= 8'd50;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_LATCH_HOLD: cfg_q.latch_hold_ticks <= cfg_data;
				CFG_CLOCK_HIGH: cfg_q.clock_high_ticks <= cfg_data;
				CFG_CLOCK_LOW:  cfg_q.clock_low_ticks  <= cfg_data;
				CFG_REPORT:     cfg_q.report_period    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_stall = result_valid_q && result_stall;
	assign tick       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (tick) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	dgsr_seq #(.BUTTON_BITS(BUTTON_BITS)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cfg    (cfg_q),
		.ctrl   (ctrl),
		.status (status)
	);

	dgsr_lane #(.BUTTON_BITS(BUTTON_BITS)) u_lane_one (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.ctrl   (ctrl),
		.data   (item.pad_one_data),
		.code   (code_one)
	);

	dgsr_lane #(.BUTTON_BITS(BUTTON_BITS)) u_lane_two (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.ctrl   (ctrl),
		.data   (item.pad_two_data),
		.code   (code_two)
	);

	// Merge: pad two codes carry the 0x10 marker.
	assign result_valid         = result_valid_q;
	assign result.latch_out     = status.latch_out;
	assign result.clock_out     = status.clock_out;
	assign result.pad_one_code  = code_one;
	assign result.pad_two_code  = {1'b1, code_two};
	assign result.frame_done    = status.frame_done;
	assign result.report_strobe = status.report_strobe;

	`DGSR_ASSERT_NOW(a_no_overlap, result_valid, !(result.latch_out && result.clock_out))
	`DGSR_ASSERT_NOW(a_done_clock, result_valid && result.frame_done,
		result.clock_out && !result.latch_out)
	`DGSR_ASSERT_NOW(a_pad_two_mark, result_valid, result.pad_two_code[4])
	`DGSR_ASSERT_NEXT(a_tick_result, tick, result_valid)

endmodule

[rtl/core/dgsr_lane.sv]
module dgsr_lane
	import dgsr_pkg::*;
#(
	parameter int BUTTON_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick,
	input  lane_ctrl_t ctrl,
	input  logic       data,
	output logic [3:0] code
);

	logic [BUTTON_BITS-1:0] shift_q;
	logic [BUTTON_BITS-1:0] word;
	logic [3:0]             code_dec;
	logic [3:0]             code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			code_q  <= '0;
		end else if (tick) begin
			if (ctrl.clear) begin
				shift_q <= '0;
			end else if (ctrl.load) begin
				shift_q <= BUTTON_BITS'(data);
			end else if (ctrl.shift) begin
				shift_q <= {shift_q[BUTTON_BITS-2:0], data};
			end
			if (ctrl.done) begin
				code_q <= code_dec;
			end
		end
	end

	// The lines are active low, so the word is inverted before matching.
	assign word = ~shift_q;

	always_comb begin
		code_dec = '0;
		for (int k = 0; k < MASK_COUNT; k++) begin
			if (32'(word) == 32'(BUTTON_MASK[k])) begin
				code_dec = 4'(k + 1);
			end
		end
	end

	assign code = code_q;

endmodule

[rtl/core/dgsr_seq.sv]
module dgsr_seq
	import dgsr_pkg::*;
#(
	parameter int BUTTON_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  cfg_t        cfg,
	output lane_ctrl_t  ctrl,
	output seq_status_t status
);

	phase_t     phase_q, phase_d;
	logic [7:0] wait_q, wait_d;
	logic [3:0] bits_q, bits_d;
	logic [7:0] report_q, report_d;
	logic       done_q, strobe_q, strobe_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			wait_q   <= '0;
			bits_q   <= '0;
			report_q <= '0;
			done_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else if (tick) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			bits_q   <= bits_d;
			report_q <= report_d;
			done_q   <= ctrl.done;
			strobe_q <= strobe_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		bits_d  = bits_q;
		ctrl    = '0;
		unique case (phase_q)
			PH_INIT: begin
				phase_d = PH_LATCH;
			end
			PH_LATCH: begin
				if (wait_q < cfg.latch_hold_ticks) begin
					wait_d = wait_q + 8'd1;
				end else begin
					wait_d    = '0;
					bits_d    = '0;
					ctrl.load = 1'b1;
					phase_d   = PH_RISE;
				end
			end
			PH_RISE: begin
				phase_d = PH_HIGH;
			end
			PH_HIGH: begin
				if (wait_q < cfg.clock_high_ticks) begin
					wait_d = wait_q + 8'd1;
				end else begin
					wait_d     = '0;
					bits_d     = bits_q + 4'd1;
					ctrl.shift = 1'b1;
					phase_d    = PH_LOWW;
				end
			end
			PH_LOWW: begin
				if (wait_q < cfg.clock_low_ticks) begin
					wait_d = wait_q + 8'd1;
				end else if ({1'b0, bits_q} + 5'd1 >= 5'(BUTTON_BITS)) begin
					ctrl.done = 1'b1;
					phase_d   = PH_FINAL;
				end else begin
					wait_d  = '0;
					phase_d = PH_RISE;
				end
			end
			default: begin
				// Start, final and the unused code all restart the frame.
				wait_d     = '0;
				bits_d     = '0;
				ctrl.clear = 1'b1;
				phase_d    = PH_INIT;
			end
		endcase
	end

	always_comb begin
		if (report_q < cfg.report_period) begin
			report_d = report_q + 8'd1;
			strobe_d = 1'b0;
		end else begin
			report_d = '0;
			strobe_d = 1'b1;
		end
	end

	assign status.latch_out     = (phase_q == PH_LATCH);
	assign status.clock_out     = (phase_q == PH_HIGH) || (phase_q == PH_LOWW) ||
		(phase_q == PH_FINAL);
	assign status.frame_done    = done_q;
	assign status.report_strobe = strobe_q;

endmodule

[dv/dgsr_pad_checker.sv]
module dgsr_pad_checker
	import dgsr_pkg::*;
#(
	parameter int BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_stall,
	input  item_t                  item,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  result_t                result,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	output int                     mismatches,
	output int                     ticks_in_flight,
	output logic                   latch_line,
	output logic                   clock_line,
	output int                     ticks_seen,
	output int                     frames_seen,
	output int                     presses_one,
	output int                     presses_two,
	output int                     strobes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Entry k of this table is the pressed-button word that decodes to code k+1.
	localparam logic [63:0] PAD_MASKS = {
		8'h80, 8'h40, 8'h10, 8'h20, 8'h01, 8'h02, 8'h04, 8'h08
	};
	localparam logic [4:0] PAD_TWO_BASE = 5'h10;

	logic [7:0]      hold_ticks, high_ticks, low_ticks, period_ticks;
	phase_t          seq_phase;
	logic [7:0]      wait_cnt, report_cnt;
	logic [3:0]      bits_in;
	logic [3:0]      code_one;
	logic [4:0]      code_two;
	logic [BITS-1:0] word_one, word_two;
	result_t         predicted;
	result_t         tick_outputs_q [$];

	function automatic logic [3:0] button_code(input logic [BITS-1:0] raw);
		logic [BITS-1:0] pressed;
		logic [3:0]      code;
		pressed = ~raw;
		code = '0;
		for (int k = 0; k < 8; k++)
			if (pressed == PAD_MASKS[6'(k * 8) +: 8])
				code = 4'(k + 1);
		return code;
	endfunction

	task automatic step_pad_sequencer(input item_t tick, output result_t r);
		logic done, strobe;
		done = 1'b0;
		strobe = 1'b0;
		case (seq_phase)
			PH_INIT: seq_phase = PH_LATCH;
			PH_LATCH: begin
				if (wait_cnt < hold_ticks) begin
					wait_cnt = wait_cnt + 8'd1;
				end else begin
					// The first bit is already on the lines when the latch drops.
					wait_cnt = '0;
					word_one = '0;
					word_two = '0;
					word_one[0] = tick.pad_one_data;
					word_two[0] = tick.pad_two_data;
					bits_in = '0;
					seq_phase = PH_RISE;
				end
			end
			PH_RISE: seq_phase = PH_HIGH;
			PH_HIGH: begin
				if (wait_cnt < high_ticks) begin
					wait_cnt = wait_cnt + 8'd1;
				end else begin
					wait_cnt = '0;
					word_one = {word_one[BITS-2:0], tick.pad_one_data};
					word_two = {word_two[BITS-2:0], tick.pad_two_data};
					bits_in = bits_in + 4'd1;
					seq_phase = PH_LOWW;
				end
			end
			PH_LOWW: begin
				if (wait_cnt < low_ticks) begin
					wait_cnt = wait_cnt + 8'd1;
				end else if (int'(bits_in) + 1 >= BITS) begin
					code_one = button_code(word_one);
					code_two = PAD_TWO_BASE | 5'(button_code(word_two));
					done = 1'b1;
					seq_phase = PH_FINAL;
				end else begin
					wait_cnt = '0;
					seq_phase = PH_RISE;
				end
			end
			default: begin
				wait_cnt = '0;
				bits_in = '0;
				word_one = '0;
				word_two = '0;
				seq_phase = PH_INIT;
			end
		endcase

		// A count left above a lowered period still fires once and wraps.
		if (report_cnt < period_ticks) begin
			report_cnt = report_cnt + 8'd1;
		end else begin
			report_cnt = '0;
			strobe = 1'b1;
		end

		r.latch_out = (seq_phase == PH_LATCH);
		r.clock_out = (seq_phase == PH_HIGH) || (seq_phase == PH_LOWW) ||
			(seq_phase == PH_FINAL);
		r.pad_one_code = code_one;
		r.pad_two_code = code_two;
		r.frame_done = done;
		r.report_strobe = strobe;
	endtask

	task automatic compare_field(input string name, input logic [4:0] want, input logic [4:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks = 8'd2;
			high_ticks = 8'd2;
			low_ticks = 8'd4;
			period_ticks = 8'd50;
			seq_phase = PH_START;
			wait_cnt = '0;
			bits_in = '0;
			word_one = '0;
			word_two = '0;
			code_one = '0;
			code_two = PAD_TWO_BASE;
			report_cnt = '0;
			tick_outputs_q.delete();
			latch_line = 1'b0;
			clock_line = 1'b0;
			ticks_in_flight = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (tick_outputs_q.size() == 0) begin
					$error("result transfer with no tick outstanding");
					mismatches++;
				end else begin
					predicted = tick_outputs_q.pop_front();
					compare_field("latch_out", 5'(predicted.latch_out),
						5'(result.latch_out));
					compare_field("clock_out", 5'(predicted.clock_out),
						5'(result.clock_out));
					compare_field("pad_one_code", 5'(predicted.pad_one_code),
						5'(result.pad_one_code));
					compare_field("pad_two_code", predicted.pad_two_code,
						result.pad_two_code);
					compare_field("frame_done", 5'(predicted.frame_done),
						5'(result.frame_done));
					compare_field("report_strobe", 5'(predicted.report_strobe),
						5'(result.report_strobe));
				end
			end

			// A tick taken at the same edge as a register write still sees the old value.
			if (item_valid && !item_stall) begin
				step_pad_sequencer(item, predicted);
				tick_outputs_q.push_back(predicted);
				ticks_seen++;
				if (predicted.frame_done) begin
					frames_seen++;
					if (predicted.pad_one_code != '0)
						presses_one++;
					if (predicted.pad_two_code != PAD_TWO_BASE)
						presses_two++;
				end
				if (predicted.report_strobe)
					strobes_seen++;
				latch_line = predicted.latch_out;
				clock_line = predicted.clock_out;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_LATCH_HOLD: hold_ticks = cfg_data;
					CFG_CLOCK_HIGH: high_ticks = cfg_data;
					CFG_CLOCK_LOW:  low_ticks = cfg_data;
					CFG_REPORT:     period_ticks = cfg_data;
					default: ;
				endcase
			end
			ticks_in_flight = tick_outputs_q.size();
		end
	end

endmodule

[dv/dual_gamepad_serial_reader_test.sv]
module dual_gamepad_serial_reader_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dgsr_pkg::*;

	localparam int TICKS_PER_SETTING = 200;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	item_t                  item;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	int   chk_mismatches, chk_in_flight;
	logic chk_latch, chk_clock;
	int   chk_ticks, chk_frames, chk_presses_one, chk_presses_two, chk_strobes;

	// Shared between the sender, the receiver and the phase sequence.
	bit         quiet;
	bit         hold_request;
	int         hold_left;
	int         settings_used;
	int         idle_cycles = 0;

	// Pad model: what the two controllers put on their data lines.
	logic [7:0] raw_one, raw_two;
	int         pad_bit;
	logic       in_latch, last_clock;
	bit         chatter;
	logic [7:0] hold_val, high_val, low_val, period_val;

	dual_gamepad_serial_reader #(.BUTTON_BITS(8)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	dgsr_pad_checker #(.BITS(8)) pad_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (chk_mismatches),
		.ticks_in_flight (chk_in_flight),
		.latch_line      (chk_latch),
		.clock_line      (chk_clock),
		.ticks_seen      (chk_ticks),
		.frames_seen     (chk_frames),
		.presses_one     (chk_presses_one),
		.presses_two     (chk_presses_two),
		.strobes_seen    (chk_strobes)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly a single pressed button, sometimes none, sometimes garbage.
	function automatic logic [7:0] pad_word();
		int kind;
		kind = $urandom_range(99);
		if (kind < 70)
			return ~(8'h01 << $urandom_range(7));
		else if (kind < 80)
			return 8'hFF;
		else
			return 8'($urandom);
	endfunction

	task automatic send_tick();
		item_t tick;
		// Follow the predicted latch and clock lines like a real pair of pads.
		if (chk_latch) begin
			if (!in_latch) begin
				raw_one = pad_word();
				raw_two = pad_word();
				chatter = ($urandom_range(9) == 0);
			end
			pad_bit = 0;
		end else if (chk_clock && !last_clock) begin
			pad_bit++;
		end
		in_latch = chk_latch;
		last_clock = chk_clock;

		if (chatter || pad_bit > 7) begin
			tick = item_t'(2'($urandom_range(3)));
		end else begin
			tick.pad_one_data = raw_one[3'(7 - pad_bit)];
			tick.pad_two_data = raw_two[3'(7 - pad_bit)];
		end

		while (!quiet && $urandom_range(99) < 14) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= tick;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] hold, high, low, period);
		write_reg(CFG_LATCH_HOLD, hold);
		write_reg(CFG_CLOCK_HIGH, high);
		write_reg(CFG_CLOCK_LOW, low);
		write_reg(CFG_REPORT, period);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Let every outstanding transfer drain before touching the registers.
	task automatic settle();
		item_valid <= 1'b0;
		while (chk_in_flight != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		result_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !quiet && ($urandom_range(99) < 14);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		pad_bit = 0;
		in_latch = 1'b0;
		last_clock = 1'b0;
		chatter = 1'b0;
		raw_one = 8'hFF;
		raw_two = 8'hFF;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Park the sequencer deep in a long latch wait, then cut the hold below
		// the running count and drop the report period under the report count.
		set_config(8'd255, 8'd2, 8'd4, 8'd50);
		repeat (12) send_tick();
		settle();
		set_config(8'd3, 8'd2, 8'd4, 8'd0);
		repeat (12) send_tick();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: {hold_val, high_val, low_val, period_val} = {8'd0, 8'd0, 8'd0, 8'd0};
				1: {hold_val, high_val, low_val, period_val} = {8'd2, 8'd2, 8'd4, 8'd50};
				2: {hold_val, high_val, low_val, period_val} = {8'd255, 8'd0, 8'd0, 8'd255};
				3: {hold_val, high_val, low_val, period_val} = {8'd1, 8'd1, 8'd1, 8'd9};
				4: {hold_val, high_val, low_val, period_val} = {8'd0, 8'd255, 8'd0, 8'd3};
				5: {hold_val, high_val, low_val, period_val} = {8'd0, 8'd0, 8'd255, 8'd128};
				6: begin
					hold_val = 8'($urandom_range(3));
					high_val = 8'($urandom_range(3));
					low_val = 8'($urandom_range(3));
					period_val = 8'($urandom_range(255));
				end
				default: begin
					hold_val = 8'($urandom_range(7));
					high_val = 8'($urandom_range(7));
					low_val = 8'($urandom_range(7));
					period_val = 8'($urandom_range(31));
				end
			endcase
			settle();
			set_config(hold_val, high_val, low_val, period_val);
			quiet = (p == 1);
			// The result side backs up while ticks keep coming.
			if (p == 3)
				hold_request = 1'b1;
			repeat (TICKS_PER_SETTING) send_tick();
		end
		quiet = 1'b0;
		settle();

		$display("Checked %0d pad ticks under %0d register settings, with stalls on both sides.",
			chk_ticks, settings_used);
		$display("%0d frames read, %0d/%0d with a single button on pad one/two, %0d report strobes.",
			chk_frames, chk_presses_one, chk_presses_two, chk_strobes);
		if (chk_mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dgsr_pkg.sv
rtl/core/dgsr_lane.sv
rtl/core/dgsr_seq.sv
rtl/core/dual_gamepad_serial_reader.sv
dv/dgsr_pad_checker.sv
dv/dual_gamepad_serial_reader_test.sv
